// File: rtl/core/battery_health_statistics_monitor_defines.svh
// assertion helpers shared by the monitor rtl
`ifndef BATTERY_HEALTH_STATISTICS_MONITOR_DEFINES_SVH
`define BATTERY_HEALTH_STATISTICS_MONITOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BHSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BHSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bhsm_pkg.sv
package bhsm_pkg;

    localparam int TBL_DEPTH = 40;
    localparam int TBL_AW    = 6;
    localparam int STAT_W    = 17;
    localparam int TEMP_W    = 12;
    localparam int VBAT_W    = 13;
    localparam int CAP_W     = 16;
    localparam int RUN_W     = 8;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int N_SENSOR  = 4;

    // op codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_DAY    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // register indexes
    localparam logic [1:0] REG_OV_THRESH  = 2'd0;
    localparam logic [1:0] REG_OV_LIMIT   = 2'd1;
    localparam logic [1:0] REG_USB_THRESH = 2'd2;

    localparam logic [VBAT_W-1:0]        OV_THRESH_RST  = 13'd4400;
    localparam logic [RUN_W-1:0]         OV_LIMIT_RST   = 8'd2;
    localparam logic signed [TEMP_W-1:0] USB_THRESH_RST = 12'sd800;
    localparam logic [RUN_W-1:0]         RUN_SAT        = 8'd255;

    localparam logic signed [STAT_W-1:0] TEMP_MAX_RST = -17'sd300;
    localparam logic signed [STAT_W-1:0] TEMP_MIN_RST = 17'sd1000;
    localparam logic signed [STAT_W-1:0] CAP_MIN_RST  = 17'sd65535;
    localparam logic signed [STAT_W-1:0] COUNT_LIMIT  = 17'sd65535;

    // entries cleared by a new day: 8-15, 24-31, 34, 35, 37, 39
    localparam logic [TBL_DEPTH-1:0] DAY_MASK = 40'hAC_FF00_FF00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        ALU_KEEP,
        ALU_MAX,
        ALU_MIN,
        ALU_MIN_NZ,
        ALU_BUMP
    } t_alu_op;

    function automatic logic signed [STAT_W-1:0] entry_reset(input logic [TBL_AW-1:0] idx);
        logic signed [STAT_W-1:0] v;
        v = '0;
        if (idx[5] == 1'b0) begin
            v = idx[0] ? TEMP_MIN_RST : TEMP_MAX_RST;
        end else if (idx[5:3] == 3'b100 && idx[2] == 1'b0 && idx[0] == 1'b1) begin
            v = CAP_MIN_RST;
        end
        return v;
    endfunction

endpackage

// File: rtl/core/battery_health_statistics_monitor.sv
// battery health statistics monitor
// input channel: i_valid / o_stall, one beat per command (sample, new day,
//   clear flags, read entry); a beat is taken when i_valid is high and
//   o_stall is low
// output channel: o_valid / i_stall, exactly one result beat per command
// config: apb-style port, three registers at byte addresses 0, 4, 8;
//   pready is tied high, writes land on the access cycle
// a sample walks all 40 table entries through one shared compare/increment
//   unit, one entry per cycle with the ram read one entry ahead of the write,
//   and then posts its result; a read entry fetches the entry in a read
//   state before it posts, while new day, clear flags and skipped samples
//   post their result without a scan or read step
// o_stall is high while a command is in flight; the next beat is taken as
//   soon as the previous result sits in the output register
// if the receiver stalls, the result holds in the output register; a newer
//   command may run but waits to post its result until that beat leaves
// reset (synchronous, active low) restores the register defaults, clears the
//   flags and run count, and marks every table entry as holding its reset
//   value through per-entry valid bits, so no clearing pass is needed
`include "battery_health_statistics_monitor_defines.svh"

module battery_health_statistics_monitor (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [1:0]                            i_op,
    input  logic [1:0]                            i_charge_state,
    input  logic                                  i_skip_check,
    input  logic [bhsm_pkg::VBAT_W-1:0]           i_vbat_mv,
    input  logic signed [bhsm_pkg::TEMP_W-1:0]    i_batt_temp,
    input  logic signed [bhsm_pkg::TEMP_W-1:0]    i_charger_temp,
    input  logic signed [bhsm_pkg::TEMP_W-1:0]    i_wireless_temp,
    input  logic signed [bhsm_pkg::TEMP_W-1:0]    i_usb_temp,
    input  logic [bhsm_pkg::CAP_W-1:0]            i_full_cap,
    input  logic                                  i_capacity_valid,
    input  logic [bhsm_pkg::TBL_AW-1:0]           i_stat_index,
    // output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [bhsm_pkg::STAT_W-1:0]    o_stat_value,
    output logic                                  o_over_voltage_report,
    output logic                                  o_over_voltage_flag,
    output logic                                  o_usb_overheat_flag,
    // config port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bhsm_pkg::APB_AW-1:0]           paddr,
    input  logic [bhsm_pkg::APB_DW-1:0]           pwdata,
    output logic [bhsm_pkg::APB_DW-1:0]           prdata,
    output logic                                  pready
);

    import bhsm_pkg::*;

    // control state
    t_state                   r_state;
    t_state                   n_state;
    logic [TBL_AW-1:0]        r_ctr;
    logic [TBL_DEPTH-1:0]     r_valid;
    logic [RUN_W-1:0]         r_ov_run;
    logic                     r_ov_latched;
    logic                     r_usb_latched;
    logic                     r_out_valid;

    // config registers
    logic [VBAT_W-1:0]        r_ov_thresh;
    logic [RUN_W-1:0]         r_ov_limit;
    logic signed [TEMP_W-1:0] r_usb_thresh;

    // captured command
    logic signed [TEMP_W-1:0] r_temp [N_SENSOR];
    logic [CAP_W-1:0]         r_cap;
    logic                     r_chg;
    logic                     r_cap_ok;
    logic                     r_ov_fire;
    logic                     r_usb_fire;
    logic                     r_res_report;
    logic signed [STAT_W-1:0] r_res_value;

    // output register
    logic signed [STAT_W-1:0] r_out_value;
    logic                     r_out_report;
    logic                     r_out_ov_flag;
    logic                     r_out_usb_flag;

    // handshakes
    logic in_acc;
    logic out_free;
    logic cfg_wr;

    // voltage / usb checks at accept time
    logic             sample_go;
    logic             volt_chk;
    logic             volt_above;
    logic [RUN_W-1:0] run_next;
    logic             ov_fire_now;
    logic             usb_fire_now;

    // scan datapath
    logic [TBL_AW-1:0]        upd_idx;
    logic                     rd_en;
    logic [TBL_AW-1:0]        rd_addr;
    logic [STAT_W-1:0]        rd_data;
    logic                     wr_en;
    logic signed [STAT_W-1:0] old_val;
    logic signed [STAT_W-1:0] operand;
    logic signed [STAT_W-1:0] alu_new;
    t_alu_op                  alu_op;
    logic                     all_en;
    logic                     cap_en;
    logic                     load_out;
    logic                     rd_in_range;
    logic signed [STAT_W-1:0] read_val;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign sample_go    = (i_op == OP_SAMPLE) && !i_skip_check;
    assign volt_chk     = (i_charge_state == 2'd0) || (i_charge_state == 2'd1);
    assign volt_above   = i_vbat_mv > r_ov_thresh;
    assign run_next     = volt_above ? ((r_ov_run < RUN_SAT) ? r_ov_run + RUN_W'(1) : r_ov_run)
                                     : '0;
    assign ov_fire_now  = volt_chk && (run_next >= r_ov_limit) && !r_ov_latched;
    assign usb_fire_now = (i_charge_state == 2'd0) && (i_usb_temp > r_usb_thresh)
                          && !r_usb_latched;

    // entry under update trails the read address by one
    assign upd_idx = r_ctr - TBL_AW'(1);
    assign all_en  = r_chg || r_cap_ok;
    assign cap_en  = !r_chg && r_cap_ok;

    // resolve stale entries to their reset value
    assign old_val = r_valid[upd_idx] ? $signed(rd_data) : entry_reset(upd_idx);

    assign rd_in_range = r_ctr < TBL_AW'(TBL_DEPTH);
    assign read_val    = !rd_in_range ? '0
                       : (r_valid[r_ctr] ? $signed(rd_data) : entry_reset(r_ctr));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (sample_go) begin
                        n_state = ST_SCAN;
                    end else if (i_op == OP_READ) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (r_ctr == TBL_AW'(TBL_DEPTH)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_READ: n_state = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // per-entry update kind for the shared unit
    always_comb begin
        alu_op = ALU_KEEP;
        if (upd_idx[5] == 1'b0) begin
            // temperature groups: life all, day all, life chg, day chg
            if (upd_idx[4] ? r_chg : all_en) begin
                alu_op = upd_idx[0] ? ALU_MIN : ALU_MAX;
            end
        end else if (upd_idx[5:3] == 3'b100) begin
            unique case (upd_idx[2:1])
                2'd0, 2'd1: begin
                    if (cap_en) begin
                        alu_op = upd_idx[0] ? ALU_MIN_NZ : ALU_MAX;
                    end
                end
                2'd2: alu_op = r_ov_fire ? ALU_BUMP : ALU_KEEP;
                2'd3: alu_op = r_usb_fire ? ALU_BUMP : ALU_KEEP;
                default: alu_op = ALU_KEEP;
            endcase
        end
    end

    // operand for the shared unit
    always_comb begin
        if (upd_idx[5] == 1'b0) begin
            operand = STAT_W'(r_temp[upd_idx[2:1]]);
        end else begin
            operand = $signed({1'b0, r_cap});
        end
    end

    // control outputs
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = r_ctr;
        wr_en    = 1'b0;
        load_out = 1'b0;
        o_stall  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                rd_addr = i_stat_index;
                rd_en   = in_acc && (i_op == OP_READ)
                          && (i_stat_index < TBL_AW'(TBL_DEPTH));
            end
            ST_SCAN: begin
                rd_en = rd_in_range;
                wr_en = (r_ctr != '0) && (alu_op != ALU_KEEP);
            end
            ST_READ: begin
                rd_en = 1'b0;
            end
            ST_FINISH: begin
                load_out = out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    bhsm_ram #(
        .WIDTH (STAT_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (upd_idx),
        .i_wr_data (alu_new),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bhsm_alu u_alu (
        .i_op      (alu_op),
        .i_old     (old_val),
        .i_operand (operand),
        .o_new     (alu_new)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_ctr         <= '0;
            r_valid       <= '0;
            r_ov_run      <= '0;
            r_ov_latched  <= 1'b0;
            r_usb_latched <= 1'b0;
            r_out_valid   <= 1'b0;
            r_ov_thresh   <= OV_THRESH_RST;
            r_ov_limit    <= OV_LIMIT_RST;
            r_usb_thresh  <= USB_THRESH_RST;
        end else begin
            r_state <= n_state;

            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_OV_THRESH:  r_ov_thresh  <= pwdata[VBAT_W-1:0];
                    REG_OV_LIMIT:   r_ov_limit   <= pwdata[RUN_W-1:0];
                    REG_USB_THRESH: r_usb_thresh <= $signed(pwdata[TEMP_W-1:0]);
                    default: ;
                endcase
            end

            if (in_acc) begin
                r_ctr <= (i_op == OP_READ) ? i_stat_index : '0;
                unique case (i_op)
                    OP_SAMPLE: begin
                        if (sample_go) begin
                            if (volt_chk) begin
                                r_ov_run <= run_next;
                            end
                            if (ov_fire_now) begin
                                r_ov_latched <= 1'b1;
                            end
                            if (usb_fire_now) begin
                                r_usb_latched <= 1'b1;
                            end
                        end
                    end
                    OP_DAY:   r_valid <= r_valid & ~DAY_MASK;
                    OP_CLEAR: begin
                        r_ov_latched  <= 1'b0;
                        r_usb_latched <= 1'b0;
                    end
                    default: ;
                endcase
            end else if (r_state == ST_SCAN) begin
                r_ctr <= r_ctr + TBL_AW'(1);
                if (wr_en) begin
                    r_valid[upd_idx] <= 1'b1;
                end
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_temp[0]    <= i_batt_temp;
            r_temp[1]    <= i_charger_temp;
            r_temp[2]    <= i_wireless_temp;
            r_temp[3]    <= i_usb_temp;
            r_cap        <= i_full_cap;
            r_chg        <= (i_charge_state == 2'd0);
            r_cap_ok     <= i_capacity_valid;
            r_ov_fire    <= sample_go && ov_fire_now;
            r_usb_fire   <= sample_go && usb_fire_now;
            r_res_report <= sample_go && ov_fire_now && (i_charge_state == 2'd0);
            r_res_value  <= '0;
        end else if (r_state == ST_READ) begin
            r_res_value <= read_val;
        end

        if (load_out) begin
            r_out_value    <= r_res_value;
            r_out_report   <= r_res_report;
            r_out_ov_flag  <= r_ov_latched;
            r_out_usb_flag <= r_usb_latched;
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_OV_THRESH:  prdata = APB_DW'(r_ov_thresh);
            REG_OV_LIMIT:   prdata = APB_DW'(r_ov_limit);
            REG_USB_THRESH: prdata = APB_DW'(r_usb_thresh);
            default:        prdata = '0;
        endcase
    end

    assign pready                = 1'b1;
    assign o_valid               = r_out_valid;
    assign o_stat_value          = r_out_value;
    assign o_over_voltage_report = r_out_report;
    assign o_over_voltage_flag   = r_out_ov_flag;
    assign o_usb_overheat_flag   = r_out_usb_flag;

    // checks
    `BHSM_ASSERT_IMP(a_scan_ctr, i_clk, i_rst_n, r_state == ST_SCAN,
        r_ctr <= TBL_AW'(TBL_DEPTH), "scan counter past table end")
    `BHSM_ASSERT_IMP(a_rw_clash, i_clk, i_rst_n, wr_en && rd_en,
        upd_idx != rd_addr, "table read and write hit one entry")
    `BHSM_ASSERT_IMP(a_report_flag, i_clk, i_rst_n, o_valid && o_over_voltage_report,
        o_over_voltage_flag, "report without flag")
    `BHSM_ASSERT_NXT(a_read_path, i_clk, i_rst_n, in_acc && (i_op == OP_READ),
        r_state == ST_READ, "read did not enter read state")

endmodule

// File: rtl/core/bhsm_ram.sv
module bhsm_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/bhsm_alu.sv
module bhsm_alu (
    input  bhsm_pkg::t_alu_op                      i_op,
    input  logic signed [bhsm_pkg::STAT_W-1:0]     i_old,
    input  logic signed [bhsm_pkg::STAT_W-1:0]     i_operand,
    output logic signed [bhsm_pkg::STAT_W-1:0]     o_new
);

    import bhsm_pkg::*;

    logic signed [STAT_W-1:0] cmp_b;
    logic signed [STAT_W:0]   diff;
    logic                     b_gt;
    logic                     b_lt;
    logic signed [STAT_W-1:0] incr;

    // one subtractor serves max, min and the saturation check
    assign cmp_b = (i_op == ALU_BUMP) ? COUNT_LIMIT : i_operand;
    assign diff  = (STAT_W+1)'(cmp_b) - (STAT_W+1)'(i_old);
    assign b_gt  = !diff[STAT_W] && (diff != '0);
    assign b_lt  = diff[STAT_W];
    assign incr  = i_old + STAT_W'(1);

    always_comb begin
        unique case (i_op)
            ALU_MAX:    o_new = b_gt ? i_operand : i_old;
            ALU_MIN:    o_new = b_lt ? i_operand : i_old;
            ALU_MIN_NZ: o_new = (b_lt && (i_operand != '0)) ? i_operand : i_old;
            ALU_BUMP:   o_new = b_gt ? incr : i_old;
            default:    o_new = i_old;
        endcase
    end

endmodule

// File: tb/sv/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bhsm_pkg::*;

    // charge states as the block sees them, unknown acts as discharging
    localparam logic [1:0] CS_CHARGING     = 2'd0;
    localparam logic [1:0] CS_NOT_CHARGING = 2'd1;
    localparam logic [1:0] CS_DISCHARGING  = 2'd2;
    localparam logic [1:0] CS_UNKNOWN      = 2'd3;

    // statistics table layout
    localparam int IDX_LIFE_ALL    = 0;
    localparam int IDX_DAY_ALL     = 8;
    localparam int IDX_LIFE_CHG    = 16;
    localparam int IDX_DAY_CHG     = 24;
    localparam int IDX_CAP_MAX     = 32;
    localparam int IDX_CAP_MIN     = 33;
    localparam int IDX_CAP_MAX_DAY = 34;
    localparam int IDX_CAP_MIN_DAY = 35;
    localparam int IDX_OV_CNT      = 36;
    localparam int IDX_OV_CNT_DAY  = 37;
    localparam int IDX_USB_CNT     = 38;
    localparam int IDX_USB_CNT_DAY = 39;

    localparam int TEMP_LO     = -500;
    localparam int TEMP_HI     = 1500;
    localparam int VBAT_TOP    = (1 << VBAT_W) - 1;
    localparam int CAP_TOP     = (1 << CAP_W) - 1;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 60;

    // one command beat, sensors in the order battery, charger, wireless, usb
    typedef struct packed {
        logic [1:0]                       op;
        logic [1:0]                       charge_state;
        logic                             skip_check;
        logic [VBAT_W-1:0]                vbat_mv;
        logic [N_SENSOR-1:0][TEMP_W-1:0]  temps;
        logic [CAP_W-1:0]                 full_cap;
        logic                             capacity_valid;
        logic [TBL_AW-1:0]                stat_index;
    } t_monitor_cmd;

    // one result beat
    typedef struct packed {
        logic [STAT_W-1:0] stat_value;
        logic              ov_report;
        logic              ov_flag;
        logic              usb_flag;
    } t_monitor_result;

    // health statistics predictor plus the queue of results still to come
    class stats_tracker;
        logic signed [STAT_W-1:0] entries [TBL_DEPTH];
        logic [RUN_W-1:0]         ov_run;
        logic                     ov_latched;
        logic                     usb_latched;
        logic [VBAT_W-1:0]        ov_thresh;
        logic [RUN_W-1:0]         ov_limit;
        logic signed [TEMP_W-1:0] usb_thresh;
        t_monitor_result          awaited_reports [$];
        int                       mismatches;

        function new();
            ov_thresh   = OV_THRESH_RST;
            ov_limit    = OV_LIMIT_RST;
            usb_thresh  = USB_THRESH_RST;
            ov_run      = '0;
            ov_latched  = 1'b0;
            usb_latched = 1'b0;
            mismatches  = 0;
            for (int i = 0; i < TBL_DEPTH; i++) entries[i] = '0;
            clear_group(IDX_LIFE_ALL);
            clear_group(IDX_LIFE_CHG);
            entries[IDX_CAP_MAX] = '0;
            entries[IDX_CAP_MIN] = CAP_MIN_RST;
            start_day();
        endfunction

        function void set_register(logic [1:0] idx, int value);
            case (idx)
                REG_OV_THRESH:  ov_thresh  = value[VBAT_W-1:0];
                REG_OV_LIMIT:   ov_limit   = value[RUN_W-1:0];
                REG_USB_THRESH: usb_thresh = value[TEMP_W-1:0];
                default: ;
            endcase
        endfunction

        function void clear_group(int base);
            for (int s = 0; s < N_SENSOR; s++) begin
                entries[base + 2*s]     = TEMP_MAX_RST;
                entries[base + 2*s + 1] = TEMP_MIN_RST;
            end
        endfunction

        function void start_day();
            clear_group(IDX_DAY_ALL);
            clear_group(IDX_DAY_CHG);
            entries[IDX_CAP_MAX_DAY] = '0;
            entries[IDX_CAP_MIN_DAY] = CAP_MIN_RST;
            entries[IDX_OV_CNT_DAY]  = '0;
            entries[IDX_USB_CNT_DAY] = '0;
        endfunction

        function void track_group(int base, logic [N_SENSOR-1:0][TEMP_W-1:0] temps);
            logic signed [STAT_W-1:0] t;
            for (int s = 0; s < N_SENSOR; s++) begin
                t = $signed(temps[s]);
                if (t > entries[base + 2*s])     entries[base + 2*s]     = t;
                if (t < entries[base + 2*s + 1]) entries[base + 2*s + 1] = t;
            end
        endfunction

        function void bump(int idx);
            if (entries[idx] < COUNT_LIMIT) entries[idx] = entries[idx] + 1;
        endfunction

        // returns the over-voltage report bit of the sample
        function logic apply_sample(t_monitor_cmd c);
            logic signed [STAT_W-1:0] usb_t;
            logic signed [STAT_W-1:0] cap;
            logic                     report;
            report = 1'b0;
            usb_t  = $signed(c.temps[3]);
            cap    = $signed({1'b0, c.full_cap});
            if (c.charge_state == CS_CHARGING || c.charge_state == CS_NOT_CHARGING) begin
                if (c.vbat_mv > ov_thresh) begin
                    if (ov_run < RUN_SAT) ov_run = ov_run + 1'b1;
                end else begin
                    ov_run = '0;
                end
                if (ov_run >= ov_limit && !ov_latched) begin
                    bump(IDX_OV_CNT);
                    bump(IDX_OV_CNT_DAY);
                    ov_latched = 1'b1;
                    report = (c.charge_state == CS_CHARGING);
                end
            end
            if (c.charge_state == CS_CHARGING) begin
                track_group(IDX_LIFE_CHG, c.temps);
                track_group(IDX_DAY_CHG, c.temps);
                if (usb_t > usb_thresh && !usb_latched) begin
                    bump(IDX_USB_CNT);
                    bump(IDX_USB_CNT_DAY);
                    usb_latched = 1'b1;
                end
            end else begin
                if (!c.capacity_valid) return report;
                if (cap > entries[IDX_CAP_MAX]) entries[IDX_CAP_MAX] = cap;
                if (cap != 0 && cap < entries[IDX_CAP_MIN]) entries[IDX_CAP_MIN] = cap;
                if (cap > entries[IDX_CAP_MAX_DAY]) entries[IDX_CAP_MAX_DAY] = cap;
                if (cap != 0 && cap < entries[IDX_CAP_MIN_DAY]) entries[IDX_CAP_MIN_DAY] = cap;
            end
            track_group(IDX_LIFE_ALL, c.temps);
            track_group(IDX_DAY_ALL, c.temps);
            return report;
        endfunction

        function void take_command(t_monitor_cmd c);
            t_monitor_result r;
            r = '0;
            case (c.op)
                OP_SAMPLE: if (!c.skip_check) r.ov_report = apply_sample(c);
                OP_DAY:    start_day();
                OP_CLEAR: begin
                    ov_latched  = 1'b0;
                    usb_latched = 1'b0;
                end
                OP_READ: if (c.stat_index < TBL_DEPTH) r.stat_value = entries[c.stat_index];
                default: ;
            endcase
            r.ov_flag  = ov_latched;
            r.usb_flag = usb_latched;
            awaited_reports.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_monitor_result got);
            t_monitor_result want;
            if (awaited_reports.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, actual value %0d",
                         $time, $signed(got.stat_value));
                mismatches++;
                return;
            end
            want = awaited_reports.pop_front();
            compare_field("stat_value", $signed(want.stat_value), $signed(got.stat_value));
            compare_field("over_voltage_report", want.ov_report, got.ov_report);
            compare_field("over_voltage_flag", want.ov_flag, got.ov_flag);
            compare_field("usb_overheat_flag", want.usb_flag, got.usb_flag);
        endfunction
    endclass

    // clock, reset and every block input start at a known value
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [1:0]                  i_op = OP_READ;
    logic [1:0]                  i_charge_state = CS_CHARGING;
    logic                        i_skip_check = 1'b0;
    logic [VBAT_W-1:0]           i_vbat_mv = '0;
    logic signed [TEMP_W-1:0]    i_batt_temp = '0;
    logic signed [TEMP_W-1:0]    i_charger_temp = '0;
    logic signed [TEMP_W-1:0]    i_wireless_temp = '0;
    logic signed [TEMP_W-1:0]    i_usb_temp = '0;
    logic [CAP_W-1:0]            i_full_cap = '0;
    logic                        i_capacity_valid = 1'b0;
    logic [TBL_AW-1:0]           i_stat_index = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic signed [STAT_W-1:0]    o_stat_value;
    logic                        o_over_voltage_report;
    logic                        o_over_voltage_flag;
    logic                        o_usb_overheat_flag;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [APB_AW-1:0]           paddr = '0;
    logic [APB_DW-1:0]           pwdata = '0;
    logic [APB_DW-1:0]           prdata;
    logic                        pready;

    stats_tracker sb;
    int           cycle_count = 0;
    int           stall_mode = 0;
    int           stall_hold = 0;
    int           burst_left = 0;

    battery_health_statistics_monitor u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_op                  (i_op),
        .i_charge_state        (i_charge_state),
        .i_skip_check          (i_skip_check),
        .i_vbat_mv             (i_vbat_mv),
        .i_batt_temp           (i_batt_temp),
        .i_charger_temp        (i_charger_temp),
        .i_wireless_temp       (i_wireless_temp),
        .i_usb_temp            (i_usb_temp),
        .i_full_cap            (i_full_cap),
        .i_capacity_valid      (i_capacity_valid),
        .i_stat_index          (i_stat_index),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_stat_value          (o_stat_value),
        .o_over_voltage_report (o_over_voltage_report),
        .o_over_voltage_flag   (o_over_voltage_flag),
        .o_usb_overheat_flag   (o_usb_overheat_flag),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: values sampled at the edge are the pre-edge ones, so a
    // beat is taken exactly when the block sees valid high and stall low
    always @(posedge i_clk) begin
        t_monitor_result got;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            got.stat_value = o_stat_value;
            got.ov_report  = o_over_voltage_report;
            got.ov_flag    = o_over_voltage_flag;
            got.usb_flag   = o_usb_overheat_flag;
            sb.check_result(got);
        end
        // stall pattern switches at random times between never, light random,
        // periodic and heavy random
        if (stall_hold == 0) begin
            stall_mode <= $urandom_range(3);
            stall_hold <= $urandom_range(300, 20);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(99) < 30);
            2:       i_stall <= ((cycle_count % 5) < 2);
            default: i_stall <= ($urandom_range(99) < 75);
        endcase
    end

    // one command beat: hold the payload until taken, then maybe idle a while
    task automatic send_command(t_monitor_cmd c);
        i_valid          <= 1'b1;
        i_op             <= c.op;
        i_charge_state   <= c.charge_state;
        i_skip_check     <= c.skip_check;
        i_vbat_mv        <= c.vbat_mv;
        i_batt_temp      <= c.temps[0];
        i_charger_temp   <= c.temps[1];
        i_wireless_temp  <= c.temps[2];
        i_usb_temp       <= c.temps[3];
        i_full_cap       <= c.full_cap;
        i_capacity_valid <= c.capacity_valid;
        i_stat_index     <= c.stat_index;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_command(c);
        // bursts of back-to-back beats, then a gap that may land anywhere
        // in the block's scan
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(16, 1);
            if ($urandom_range(99) >= 30) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(48, 1)) @(posedge i_clk);
            end
        end
    endtask

    // wait until every result is back so the block is idle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.awaited_reports.size() != 0) @(posedge i_clk);
    endtask

    // setup then access phase; psel stays up so writes can run back to back
    task automatic write_register(logic [1:0] idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_register(idx, value);
    endtask

    function automatic logic [TEMP_W-1:0] random_temp();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) return TEMP_W'(TEMP_LO);
        if (pick < 10) return TEMP_W'(TEMP_HI);
        return TEMP_W'(int'($urandom_range(TEMP_HI - TEMP_LO)) + TEMP_LO);
    endfunction

    // random command; ov_pct biases the voltage above the current threshold,
    // sample_pct sets how many beats are samples
    function automatic t_monitor_cmd random_command(int ov_pct, int sample_pct);
        t_monitor_cmd c;
        int           pick;
        int           th;
        th   = sb.ov_thresh;
        pick = $urandom_range(99);
        if (pick < sample_pct) begin
            c.op = OP_SAMPLE;
        end else begin
            pick = $urandom_range(99);
            c.op = (pick < 15) ? OP_DAY : (pick < 30) ? OP_CLEAR : OP_READ;
        end
        pick = $urandom_range(99);
        c.charge_state = (pick < 45) ? CS_CHARGING : (pick < 70) ? CS_NOT_CHARGING :
                         (pick < 95) ? CS_DISCHARGING : CS_UNKNOWN;
        c.skip_check = ($urandom_range(99) < 8);
        if (th < VBAT_TOP && $urandom_range(99) < ov_pct)
            c.vbat_mv = VBAT_W'($urandom_range(VBAT_TOP, th + 1));
        else
            c.vbat_mv = VBAT_W'($urandom_range(th, 0));
        for (int s = 0; s < N_SENSOR; s++) c.temps[s] = random_temp();
        pick = $urandom_range(99);
        c.full_cap = (pick < 10) ? '0 : (pick < 20) ? CAP_W'(CAP_TOP) :
                     CAP_W'($urandom_range(CAP_TOP));
        c.capacity_valid = ($urandom_range(99) < 90);
        c.stat_index = ($urandom_range(99) < 93) ? TBL_AW'($urandom_range(TBL_DEPTH - 1))
                                                 : TBL_AW'($urandom_range(63, TBL_DEPTH));
        return c;
    endfunction

    function automatic t_monitor_cmd sample_cmd(logic [1:0] cs, logic skip, int vbat,
                                                int bt, int ct, int wt, int ut,
                                                int cap, logic cap_ok);
        t_monitor_cmd c;
        c = random_command(50, 100);
        c.op             = OP_SAMPLE;
        c.charge_state   = cs;
        c.skip_check     = skip;
        c.vbat_mv        = VBAT_W'(vbat);
        c.temps          = {TEMP_W'(ut), TEMP_W'(wt), TEMP_W'(ct), TEMP_W'(bt)};
        c.full_cap       = CAP_W'(cap);
        c.capacity_valid = cap_ok;
        return c;
    endfunction

    task automatic send_op(logic [1:0] op, int idx);
        t_monitor_cmd c;
        c = random_command(50, 0);
        c.op = op;
        c.stat_index = TBL_AW'(idx);
        send_command(c);
    endtask

    // directed part, run with the reset settings
    task automatic run_directed();
        // reset values of a max, a min, the capacity min and a count
        send_op(OP_READ, IDX_LIFE_ALL);
        send_op(OP_READ, IDX_LIFE_ALL + 1);
        send_op(OP_READ, IDX_CAP_MIN);
        send_op(OP_READ, IDX_OV_CNT);
        // two charging samples over the threshold latch the fault and report,
        // temperature extremes and usb overheat on the way
        send_command(sample_cmd(CS_CHARGING, 1'b0, VBAT_TOP, TEMP_HI, TEMP_LO, 0, TEMP_HI,
                                100, 1'b1));
        send_command(sample_cmd(CS_CHARGING, 1'b0, VBAT_TOP, TEMP_LO, TEMP_HI, -1, TEMP_LO,
                                100, 1'b1));
        // zero capacity must not lower the minimum
        send_command(sample_cmd(CS_NOT_CHARGING, 1'b0, 0, TEMP_LO, TEMP_LO, TEMP_LO,
                                TEMP_LO, 0, 1'b1));
        // discharging skips the voltage check, capacity at the top
        send_command(sample_cmd(CS_DISCHARGING, 1'b0, VBAT_TOP, TEMP_HI, TEMP_HI, TEMP_HI,
                                TEMP_HI, CAP_TOP, 1'b1));
        // unknown charge state behaves as discharging
        send_command(sample_cmd(CS_UNKNOWN, 1'b0, VBAT_TOP, 20, 30, 40, 50, 1234, 1'b1));
        // failed gauge read ends the sample early
        send_command(sample_cmd(CS_NOT_CHARGING, 1'b0, 0, TEMP_HI, TEMP_LO, TEMP_HI,
                                TEMP_LO, 7, 1'b0));
        // skipped sample changes nothing
        send_command(sample_cmd(CS_CHARGING, 1'b1, VBAT_TOP, TEMP_HI, TEMP_HI, TEMP_LO,
                                TEMP_HI, 1, 1'b1));
        send_op(OP_CLEAR, 0);
        // usb overheat latches again after the clear
        send_command(sample_cmd(CS_CHARGING, 1'b0, VBAT_TOP, 0, 0, 0, TEMP_HI, 5, 1'b1));
        send_op(OP_READ, IDX_CAP_MAX);
        send_op(OP_READ, IDX_CAP_MIN);
        send_op(OP_READ, IDX_CAP_MIN_DAY);
        send_op(OP_READ, IDX_OV_CNT);
        send_op(OP_READ, IDX_USB_CNT);
        // new day clears the day entries only
        send_op(OP_DAY, 0);
        send_op(OP_READ, IDX_DAY_ALL + 1);
        send_op(OP_READ, IDX_OV_CNT_DAY);
        // reads past the table return zero
        send_op(OP_READ, TBL_DEPTH);
        send_op(OP_READ, 63);
    endtask

    // one setting of the registers followed by random traffic
    task automatic run_phase(int thresh, int limit, int usb, int n_items,
                             int ov_pct, int sample_pct);
        t_monitor_cmd c;
        int           counted;
        counted = 0;
        drain();
        write_register(REG_OV_THRESH, thresh);
        write_register(REG_OV_LIMIT, limit);
        write_register(REG_USB_THRESH, usb);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        while (counted < n_items) begin
            c = random_command(ov_pct, sample_pct);
            send_command(c);
            // skipped samples are ignored by the block and do not count
            if (!(c.op == OP_SAMPLE && c.skip_check)) counted++;
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        // reset settings written back explicitly
        run_phase(OV_THRESH_RST, OV_LIMIT_RST, USB_THRESH_RST, 80, 30, 72);
        // lowest threshold, a run limit of one, coldest usb limit
        run_phase(0, 1, TEMP_LO, 80, 50, 72);
        // voltage can never exceed the top threshold
        run_phase(VBAT_TOP, RUN_SAT, TEMP_HI, 80, 50, 72);
        // long over-voltage stretch: the run count saturates and the
        // longest limit is reached
        run_phase(3000, RUN_SAT, 200, 500, 100, 95);
        // a zero limit latches on any checked sample
        run_phase(4200, 0, 1000, 80, 40, 72);
        run_phase($urandom_range(6000, 3000), $urandom_range(6, 1),
                  int'($urandom_range(1200)) - 300, 100, 35, 72);
        drain();
        // let anything stray show up before deciding
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog on the cycle counter
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout with %0d results outstanding", $time,
                 sb.awaited_reports.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
